>>> hdl/lru_key_cache_tracker_assert.svh
// Assertion macros for the LRU key cache tracker.
`ifndef LRU_KEY_CACHE_TRACKER_ASSERT_SVH
`define LRU_KEY_CACHE_TRACKER_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define LKC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkc check failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define LKC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkc check failed");

`endif

>>> hdl/lkc_pkg.sv
package lkc_pkg;
    localparam int unsigned NUM_KEYS     = 1024;
    localparam int unsigned MAX_CAPACITY = 64;
    localparam int unsigned KEY_W        = $clog2(NUM_KEYS);
    localparam int unsigned LINK_W       = KEY_W + 1;
    localparam int unsigned PREV_W       = LINK_W + 1;
    localparam int unsigned CAP_W        = 7;
    localparam int unsigned CNT_W        = $clog2(MAX_CAPACITY + 2);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_KEYS);
    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(64);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_HIT_N,
        S_LINK,
        S_LINK_HEAD,
        S_EV_READ,
        S_EV_FIX
    } t_state;
endpackage

>>> hdl/lru_key_cache_tracker.sv
// LRU key cache tracker: cached keys form a doubly linked list held in two link memories.
// Requests are taken one at a time; the next one can be taken at the edge that ends the cycle
// in which the last result shows. An insert that evicts k keys shows one result per evicted
// key. Reset (synchronous, active low) empties the list, sets capacity to 64 and then clears
// the present bits in a pass over all keys.
`include "lru_key_cache_tracker_assert.svh"
module lru_key_cache_tracker
    import lkc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_key,
    input  logic             i_fetch_ok,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    output logic             o_busy,
    output logic             o_valid,
    output logic             o_hit,
    output logic             o_inserted,
    output logic             o_failed,
    output logic             o_evict_valid,
    output logic [KEY_W-1:0] o_evicted_key,
    output logic             o_last
);
    // Each prev entry carries the key's present bit above its prev link. The
    // present bits are cleared by a pass over all keys after reset, with busy
    // held high. The links are undefined until written and are only read at
    // keys whose present bit is set.
    logic [PREV_W-1:0] r_prev_mem [NUM_KEYS];
    logic [LINK_W-1:0] r_next_mem [NUM_KEYS];

    t_state r_state, n_state;
    logic [CAP_W-1:0]  r_cap;
    logic [LINK_W-1:0] r_head, r_tail, n_head, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [KEY_W-1:0]  r_key;
    logic              r_fetch;
    logic              r_hit;
    logic [KEY_W-1:0]  r_clr_addr;
    logic [LINK_W-1:0] r_p, r_n, n_p, n_n;
    logic [PREV_W-1:0] r_prev_rd;
    logic [LINK_W-1:0] r_next_rd;
    logic              rd_present;
    logic [LINK_W-1:0] rd_prev;

    // One synchronous read address for both memories, one write port each.
    logic [KEY_W-1:0]  rd_addr;
    logic              pw_en, nw_en;
    logic [KEY_W-1:0]  pw_addr, nw_addr;
    logic [PREV_W-1:0] pw_data;
    logic [LINK_W-1:0] nw_data;

    logic [CAP_W-1:0]  eff_cap;
    logic              over_cap;
    logic              n_valid, n_hit, n_ins, n_fail, n_ev, n_last;
    logic [KEY_W-1:0]  n_ev_key;

    assign rd_present = r_prev_rd[LINK_W];
    assign rd_prev    = r_prev_rd[LINK_W-1:0];

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CAP_W'(1);
        end else if (r_cap > CAP_W'(MAX_CAPACITY)) begin
            eff_cap = CAP_W'(MAX_CAPACITY);
        end else begin
            eff_cap = r_cap;
        end
        over_cap = (CAP_W + 1)'(r_count) > (CAP_W + 1)'(eff_cap);
    end

    always_ff @(posedge i_clk) begin
        if (pw_en) begin
            r_prev_mem[pw_addr] <= pw_data;
        end
        if (nw_en) begin
            r_next_mem[nw_addr] <= nw_data;
        end
        r_prev_rd <= r_prev_mem[rd_addr];
        r_next_rd <= r_next_mem[rd_addr];
    end

    // Next state. The request's entry is read at the accepting edge, so the
    // lookup decides from read data that is valid in S_LOOK.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == KEY_W'(NUM_KEYS - 1)) n_state = S_IDLE;
            end
            S_IDLE:      if (i_start) n_state = S_LOOK;
            S_LOOK: begin
                if (rd_present) begin
                    n_state = S_HIT_N;
                end else if (r_fetch) begin
                    n_state = S_LINK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_HIT_N:     n_state = S_LINK;
            S_LINK:      n_state = S_LINK_HEAD;
            S_LINK_HEAD: n_state = r_hit ? S_IDLE : S_EV_READ;
            S_EV_READ:   n_state = over_cap ? S_EV_FIX : S_IDLE;
            S_EV_FIX:    n_state = n_last ? S_IDLE : S_EV_READ;
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    // A hit unlinks the key in S_LOOK (next link of its prev neighbor) and
    // S_HIT_N (prev link of its next neighbor). S_LINK writes both links of
    // the key, S_LINK_HEAD points the old head back at it. An eviction reads
    // the tail's prev link in S_EV_READ and unlinks the tail in S_EV_FIX.
    // S_EV_READ is reached again only after an eviction that was not the last,
    // so there a count within capacity means the insert evicted nothing.
    always_comb begin
        rd_addr = r_key;
        pw_en = 1'b0; nw_en = 1'b0;
        pw_addr = r_key; nw_addr = r_key;
        pw_data = {1'b1, NULL_LINK}; nw_data = NULL_LINK;
        n_head = r_head; n_tail = r_tail; n_count = r_count;
        n_p = r_p; n_n = r_n;
        n_valid = 1'b0; n_hit = 1'b0; n_ins = 1'b0; n_fail = 1'b0;
        n_ev = 1'b0; n_ev_key = '0; n_last = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                pw_en = 1'b1;
                pw_addr = r_clr_addr;
                pw_data = {1'b0, NULL_LINK};
            end
            S_IDLE: begin
                rd_addr = i_key;
            end
            S_LOOK: begin
                if (rd_present) begin
                    n_p = rd_prev;
                    n_n = r_next_rd;
                    if (rd_prev != NULL_LINK) begin
                        nw_en = 1'b1;
                        nw_addr = rd_prev[KEY_W-1:0];
                        nw_data = r_next_rd;
                    end else begin
                        n_head = r_next_rd;
                    end
                end else if (!r_fetch) begin
                    n_valid = 1'b1; n_fail = 1'b1; n_last = 1'b1;
                end
            end
            S_HIT_N: begin
                if (r_n != NULL_LINK) begin
                    pw_en = 1'b1;
                    pw_addr = r_n[KEY_W-1:0];
                    pw_data = {1'b1, r_p};
                end else begin
                    n_tail = r_p;
                end
            end
            S_LINK: begin
                // Marks the key present with no prev; its next is the head.
                pw_en = 1'b1; pw_addr = r_key; pw_data = {1'b1, NULL_LINK};
                nw_en = 1'b1; nw_addr = r_key; nw_data = r_head;
            end
            S_LINK_HEAD: begin
                if (r_head != NULL_LINK) begin
                    pw_en = 1'b1;
                    pw_addr = r_head[KEY_W-1:0];
                    pw_data = {1'b1, LINK_W'(r_key)};
                end else begin
                    n_tail = LINK_W'(r_key);
                end
                n_head = LINK_W'(r_key);
                if (r_hit) begin
                    n_valid = 1'b1; n_hit = 1'b1; n_last = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            S_EV_READ: begin
                rd_addr = r_tail[KEY_W-1:0];
                if (!over_cap) begin
                    n_valid = 1'b1; n_ins = 1'b1; n_last = 1'b1;
                end
            end
            S_EV_FIX: begin
                // r_prev_rd holds the tail's entry; the victim's present bit drops.
                pw_en = 1'b1;
                pw_addr = r_tail[KEY_W-1:0];
                pw_data = {1'b0, NULL_LINK};
                n_count = r_count - CNT_W'(1);
                n_valid = 1'b1; n_ins = 1'b1; n_ev = 1'b1;
                n_ev_key = r_tail[KEY_W-1:0];
                n_tail = rd_prev;
                if (rd_prev != NULL_LINK) begin
                    nw_en = 1'b1;
                    nw_addr = rd_prev[KEY_W-1:0];
                    nw_data = NULL_LINK;
                end else begin
                    n_head = NULL_LINK;
                end
                n_last = ((CAP_W + 1)'(n_count) <= (CAP_W + 1)'(eff_cap))
                         || (rd_prev == NULL_LINK);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cap      <= CAP_RESET;
            r_head     <= NULL_LINK;
            r_tail     <= NULL_LINK;
            r_count    <= '0;
            r_clr_addr <= '0;
            o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + KEY_W'(1);
            end
            o_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_key   <= i_key;
            r_fetch <= i_fetch_ok;
        end
        if (r_state == S_LOOK) begin
            r_hit <= rd_present;
        end
        r_p <= n_p;
        r_n <= n_n;
        o_hit         <= n_hit;
        o_inserted    <= n_ins;
        o_failed      <= n_fail;
        o_evict_valid <= n_ev;
        o_evicted_key <= n_ev_key;
        o_last        <= n_last;
    end

    assign o_busy = (r_state != S_IDLE);

    `LKC_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `LKC_ASSERT_IMP(a_one_flag, i_clk, i_rst_n, o_valid, $onehot({o_hit, o_inserted, o_failed}))
    `LKC_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, r_state == S_IDLE, r_count <= CNT_W'(MAX_CAPACITY))
    `LKC_ASSERT_IMP(a_evict_ins, i_clk, i_rst_n, o_valid && o_evict_valid, o_inserted)
endmodule

>>> bench/tb.sv
module tb;
    import lkc_pkg::*;

    // One expected result of a request, in the order the block must emit them.
    typedef struct {
        bit            hit;
        bit            inserted;
        bit            failed;
        bit            evict_valid;
        bit [KEY_W-1:0] evicted_key;
        bit            last;
    } t_lru_result;

    // Scoreboard: keeps its own copy of the LRU list and predicts the results
    // of every accepted request; results from the block are checked in order.
    class t_lru_scoreboard;
        bit          cached[NUM_KEYS];
        int          prv[NUM_KEYS];
        int          nxt[NUM_KEYS];
        int          head;
        int          tail;
        int          count;
        int          capacity;
        t_lru_result pending[$];
        int          errors;
        int          requests;
        int          results;
        int          evictions;

        function new();
            foreach (cached[i]) begin
                cached[i] = 0;
                prv[i] = NUM_KEYS;
                nxt[i] = NUM_KEYS;
            end
            head = NUM_KEYS;
            tail = NUM_KEYS;
            count = 0;
            capacity = CAP_RESET;
            errors = 0;
            requests = 0;
            results = 0;
            evictions = 0;
        endfunction

        function void set_capacity(int value);
            capacity = value;
        endfunction

        function void push_front(int k);
            prv[k] = NUM_KEYS;
            nxt[k] = head;
            if (head != NUM_KEYS) begin
                prv[head] = k;
            end else begin
                tail = k;
            end
            head = k;
        endfunction

        function void unlink(int k);
            int p;
            int n;
            p = prv[k];
            n = nxt[k];
            if (p != NUM_KEYS) nxt[p] = n;
            else head = n;
            if (n != NUM_KEYS) prv[n] = p;
            else tail = p;
        endfunction

        // Works out the results of one accepted request.
        function void note_request(bit [KEY_W-1:0] k, bit ok);
            int          limit;
            int          victim;
            int          n;
            t_lru_result r;
            limit = capacity;
            if (limit < 1) limit = 1;
            if (limit > MAX_CAPACITY) limit = MAX_CAPACITY;
            r = '{default: 0};
            requests++;
            if (cached[k]) begin
                r.hit = 1;
                unlink(k);
                push_front(k);
            end else if (ok) begin
                r.inserted = 1;
                cached[k] = 1;
                push_front(k);
                count++;
            end else begin
                r.failed = 1;
            end
            n = 0;
            // Only an insert can raise the count; a hit never evicts.
            if (r.inserted) begin
                while (count > limit && tail != NUM_KEYS) begin
                    victim = tail;
                    unlink(victim);
                    cached[victim] = 0;
                    count--;
                    r.evict_valid = 1;
                    r.evicted_key = victim[KEY_W-1:0];
                    pending.push_back(r);
                    n++;
                end
            end
            if (n == 0) begin
                r.evict_valid = 0;
                r.evicted_key = '0;
                pending.push_back(r);
            end
            pending[pending.size()-1].last = 1;
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task check_result(t_lru_result got);
            t_lru_result want;
            results++;
            if (got.evict_valid) evictions++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result h=%0b i=%0b f=%0b ev=%0b k=%0d l=%0b",
                    got.hit, got.inserted, got.failed, got.evict_valid,
                    got.evicted_key, got.last));
            end else begin
                want = pending.pop_front();
                if (got.hit != want.hit)
                    report($sformatf("hit %0b, expected %0b", got.hit, want.hit));
                if (got.inserted != want.inserted)
                    report($sformatf("inserted %0b, expected %0b", got.inserted, want.inserted));
                if (got.failed != want.failed)
                    report($sformatf("failed %0b, expected %0b", got.failed, want.failed));
                if (got.evict_valid != want.evict_valid)
                    report($sformatf("evict_valid %0b, expected %0b",
                        got.evict_valid, want.evict_valid));
                if (got.evicted_key != want.evicted_key)
                    report($sformatf("evicted_key %0d, expected %0d",
                        got.evicted_key, want.evicted_key));
                if (got.last != want.last)
                    report($sformatf("last %0b, expected %0b", got.last, want.last));
            end
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic [KEY_W-1:0] i_key;
    logic             i_fetch_ok;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;
    logic             o_busy;
    logic             o_valid;
    logic             o_hit;
    logic             o_inserted;
    logic             o_failed;
    logic             o_evict_valid;
    logic [KEY_W-1:0] o_evicted_key;
    logic             o_last;

    t_lru_scoreboard sb;
    int              cycles;

    lru_key_cache_tracker uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_key        (i_key),
        .i_fetch_ok   (i_fetch_ok),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_busy       (o_busy),
        .o_valid      (o_valid),
        .o_hit        (o_hit),
        .o_inserted   (o_inserted),
        .o_failed     (o_failed),
        .o_evict_valid(o_evict_valid),
        .o_evicted_key(o_evicted_key),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Results are strobes that cannot be held off, so every valid cycle is
    // taken as it comes. Sampling at the edge sees the values of the cycle
    // that the edge ends.
    always @(posedge i_clk) begin
        t_lru_result got;
        if (i_rst_n && o_valid) begin
            got.hit = o_hit;
            got.inserted = o_inserted;
            got.failed = o_failed;
            got.evict_valid = o_evict_valid;
            got.evicted_key = o_evicted_key;
            got.last = o_last;
            sb.check_result(got);
        end
    end

    // A hung block ends the run here. The bound is many times the slowest correct run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= 400000) begin
            $display("Timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Issues one request and waits for the block to take it. The start line
    // stays high across back-to-back requests; it drops only when a gap follows.
    task send_request(input logic [KEY_W-1:0] k, input logic ok, input int gap);
        i_start <= 1'b1;
        i_key <= k;
        i_fetch_ok <= ok;
        do @(posedge i_clk); while (o_busy);
        sb.note_request(k, ok);
        if (gap > 0) begin
            i_start <= 1'b0;
            i_key <= KEY_W'($urandom);
            i_fetch_ok <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Lets every expected result arrive, then a few more cycles so that the
    // block is surely idle before the capacity changes.
    task drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task write_capacity(input logic [CAP_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_capacity(value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random requests: most keys come from a small pool so that hits and
    // evictions of cached keys are common; the rest span the whole key space.
    // Gaps are zero for long stretches, random elsewhere.
    task random_phase(input int items, input int pool);
        logic [KEY_W-1:0] k;
        int               gap;
        bool_burst:
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(0, 9) < 7) k = KEY_W'($urandom_range(0, pool));
            else k = KEY_W'($urandom);
            if ((i / 16) % 3 == 0) gap = 0;
            else gap = $urandom_range(0, 14);
            send_request(k, $urandom_range(0, 4) != 0, gap);
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_key = '0;
        i_fetch_ok = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: failed fetch on an empty list, inserts at both ends of the
        // key space, a hit at the head, a hit deeper in the list, and a hit
        // with the fetch flag low (the flag is ignored on a hit).
        send_request(10'd0, 1'b0, 2);
        send_request(10'd0, 1'b1, 0);
        send_request(10'd1023, 1'b1, 1);
        send_request(10'd1023, 1'b1, 0);
        send_request(10'd0, 1'b0, 3);
        send_request(10'd1023, 1'b0, 0);
        send_request(10'd512, 1'b0, 0);
        send_request(10'd341, 1'b1, 5);
        send_request(10'd682, 1'b1, 0);
        send_request(10'd0, 1'b1, 0);
        drain();

        // Capacity one: every insert evicts all other keys, so that only the new one stays.
        write_capacity(7'd1);
        send_request(10'd5, 1'b1, 0);
        send_request(10'd6, 1'b1, 0);
        send_request(10'd6, 1'b1, 0);
        send_request(10'd5, 1'b0, 0);
        drain();

        // Full capacity: fill the list to 64 keys, then drop the capacity to one
        // so that the next insert evicts 64 keys in one go.
        write_capacity(7'd64);
        for (int i = 0; i < 70; i++) send_request(KEY_W'(100 + i), 1'b1, (i % 7 == 0) ? 3 : 0);
        drain();
        write_capacity(7'd1);
        send_request(10'd64, 1'b0, 0);
        send_request(10'd900, 1'b1, 0);
        drain();

        // Zero clamps to one; values above 64 clamp to 64.
        write_capacity(7'd0);
        random_phase(50, 8);
        drain();
        write_capacity(7'd127);
        random_phase(90, 100);
        drain();
        write_capacity(7'd3);
        random_phase(60, 10);
        drain();
        write_capacity(CAP_W'($urandom_range(2, 64)));
        random_phase(80, 60);
        drain();
        write_capacity(7'd64);
        random_phase(60, 90);
        drain();
        write_capacity(7'd2);
        random_phase(30, 6);
        drain();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d requests, %0d results, %0d evictions over many capacity settings.",
            sb.requests, sb.results, sb.evictions);
        $display("Capacity was taken from the clamped extremes down to one and back.");
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
